// File: rtl/core/segi_pkg.sv
// shared constants and control types for the segment intersection core
package segi_pkg;

  localparam int unsigned TOL_W = 15;
  localparam logic [TOL_W-1:0] TOL_RESET = 15'd4;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

endpackage

// File: rtl/core/segi_if.sv
// valid/ready channel interfaces for segment pairs and intersection results
interface segi_pair_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_start_x;
  logic signed [W-1:0] first_start_y;
  logic signed [W-1:0] first_end_x;
  logic signed [W-1:0] first_end_y;
  logic signed [W-1:0] second_start_x;
  logic signed [W-1:0] second_start_y;
  logic signed [W-1:0] second_end_x;
  logic signed [W-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface segi_result_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;

  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

// File: rtl/core/segi_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module segi_div
  import segi_pkg::*;
#(
  parameter int unsigned W  = 16,
  parameter int unsigned NW = 51,
  parameter int unsigned DW = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  div_ctl_t            ctl_i,
  input  logic [NW-1:0]       n_i,
  input  logic [DW-1:0]       d_i,
  output div_ctl_t            ctl_o,
  output logic signed [W-1:0] q_o
);

  localparam logic [W-1:0] HALF = W'(1) << (W - 1);

  div_ctl_t       ctl_q [W+1];
  logic [NW-1:0]  rem_q [W+1];
  logic [DW-1:0]  d_q   [W+1];
  logic [W-1:0]   quo_q [W+1];
  logic           ovf_q [W+1];

  logic ovf_d;
  assign ovf_d = {1'b0, n_i} >= ({1'b0, NW'(d_i)} << W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_i;
      d_q[0]   <= d_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    logic [NW:0]   trial;
    logic          take;
    logic [W-1:0]  quo_d;
    assign trial = {1'b0, rem_q[s-1]} - ({1'b0, NW'(d_q[s-1])} << (W - s));
    assign take  = !trial[NW];
    always_comb begin
      quo_d = quo_q[s-1];
      quo_d[W-s] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else if (en_i) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? trial[NW-1:0] : rem_q[s-1];
        d_q[s]   <= d_q[s-1];
        quo_q[s] <= quo_d;
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  logic [W-1:0] qv;
  assign qv    = quo_q[W];
  assign ctl_o = ctl_q[W];

  always_comb begin
    if (ctl_q[W].neg) begin
      if (ovf_q[W] || qv > HALF) q_o = signed'(HALF);
      else                       q_o = signed'(~qv + W'(1));
    end else begin
      if (ovf_q[W] || qv > HALF - W'(1)) q_o = signed'(HALF - W'(1));
      else                                q_o = signed'(qv);
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[W].valid && !ovf_q[W] |-> rem_q[W] < NW'(d_q[W]))
    else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/segment_intersection_core.sv
// segment intersection core: determinant, crossing point, tolerance box tests
// Takes one segment pair per clock while the output is not stalled and returns
// one result per pair, in order. It has four stages of products and sums, the
// divider with one quotient bit per stage plus its entry register, and the
// output register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stalled output holds every stage. The tolerance
// register resets to 4 and must be written only while no pair is in flight.
module segment_intersection_core
  import segi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tol_we_i,
  input  logic [TOL_W-1:0]  tol_wdata_i,
  segi_pair_if.sink         pair_i,
  segi_result_if.source     result_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DXW  = W + 1;
  localparam int unsigned PW   = 2 * DXW;
  localparam int unsigned DETW = PW + 1;
  localparam int unsigned AW   = 2 * W + 1;
  localparam int unsigned MW   = DXW + AW;
  localparam int unsigned NW   = MW + 1;
  localparam int unsigned BW   = ((W > TOL_W) ? W : TOL_W) + 2;
  localparam int unsigned LW   = TOL_W + FRACTION_BITS;
  localparam int unsigned CW   = (DETW > LW) ? DETW : LW;

  typedef struct packed {
    logic                 coll;
    logic                 chit;
    logic signed [W-1:0]  cx;
    logic signed [W-1:0]  cy;
    logic signed [BW-1:0] b1xlo;
    logic signed [BW-1:0] b1xhi;
    logic signed [BW-1:0] b1ylo;
    logic signed [BW-1:0] b1yhi;
    logic signed [BW-1:0] b2xlo;
    logic signed [BW-1:0] b2xhi;
    logic signed [BW-1:0] b2ylo;
    logic signed [BW-1:0] b2yhi;
  } side_t;

  function automatic logic signed [BW-1:0] lo_of(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [BW-1:0] t);
    logic signed [BW-1:0] m;
    m = (a < b) ? BW'(a) : BW'(b);
    return m - t;
  endfunction

  function automatic logic signed [BW-1:0] hi_of(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [BW-1:0] t);
    logic signed [BW-1:0] m;
    m = (a < b) ? BW'(b) : BW'(a);
    return m + t;
  endfunction

  function automatic logic in_box(input logic signed [W-1:0] p,
                                  input logic signed [BW-1:0] lo,
                                  input logic signed [BW-1:0] hi);
    logic signed [BW-1:0] pe;
    pe = BW'(p);
    return (pe >= lo) && (pe <= hi);
  endfunction

  // tolerance register
  logic [TOL_W-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  logic                 out_valid_q;
  logic                 en;
  assign en           = !out_valid_q || result_o.ready;
  assign pair_i.ready = en;

  logic signed [BW-1:0] tol_s;
  assign tol_s = signed'(BW'(tol_q));

  // stage 1: differences, boxes, collinear outcome, first products
  logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = pair_i.first_start_x;
  assign y1 = pair_i.first_start_y;
  assign x2 = pair_i.first_end_x;
  assign y2 = pair_i.first_end_y;
  assign x3 = pair_i.second_start_x;
  assign y3 = pair_i.second_start_y;
  assign x4 = pair_i.second_end_x;
  assign y4 = pair_i.second_end_y;

  logic signed [DXW-1:0] dx12_d, dy12_d, dx34_d, dy34_d;
  assign dx12_d = DXW'(x1) - DXW'(x2);
  assign dy12_d = DXW'(y1) - DXW'(y2);
  assign dx34_d = DXW'(x3) - DXW'(x4);
  assign dy34_d = DXW'(y3) - DXW'(y4);

  side_t side1_d;
  logic  s3_in, s4_in;
  always_comb begin
    side1_d       = '0;
    side1_d.b1xlo = lo_of(x1, x2, tol_s);
    side1_d.b1xhi = hi_of(x1, x2, tol_s);
    side1_d.b1ylo = lo_of(y1, y2, tol_s);
    side1_d.b1yhi = hi_of(y1, y2, tol_s);
    side1_d.b2xlo = lo_of(x3, x4, tol_s);
    side1_d.b2xhi = hi_of(x3, x4, tol_s);
    side1_d.b2ylo = lo_of(y3, y4, tol_s);
    side1_d.b2yhi = hi_of(y3, y4, tol_s);
    s3_in = in_box(x3, side1_d.b1xlo, side1_d.b1xhi) &&
            in_box(y3, side1_d.b1ylo, side1_d.b1yhi);
    s4_in = in_box(x4, side1_d.b1xlo, side1_d.b1xhi) &&
            in_box(y4, side1_d.b1ylo, side1_d.b1yhi);
    if (s3_in) begin
      side1_d.chit = 1'b1;
      side1_d.cx   = x3;
      side1_d.cy   = y3;
    end else if (s4_in) begin
      side1_d.chit = 1'b1;
      side1_d.cx   = x4;
      side1_d.cy   = y4;
    end
  end

  logic                  v1_q;
  side_t                 side1_q;
  logic signed [DXW-1:0] dx12_q, dy12_q, dx34_q, dy34_q;
  logic signed [PW-1:0]  pd1_q, pd2_q;
  logic signed [2*W-1:0] pa1_q, pa2_q, pb1_q, pb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      dx12_q  <= dx12_d;
      dy12_q  <= dy12_d;
      dx34_q  <= dx34_d;
      dy34_q  <= dy34_d;
      pd1_q   <= PW'(dx12_d) * PW'(dy34_d);
      pd2_q   <= PW'(dy12_d) * PW'(dx34_d);
      pa1_q   <= (2*W)'(x1) * (2*W)'(y2);
      pa2_q   <= (2*W)'(y1) * (2*W)'(x2);
      pb1_q   <= (2*W)'(x3) * (2*W)'(y4);
      pb2_q   <= (2*W)'(y3) * (2*W)'(x4);
    end
  end

  // stage 2: determinant and cross terms
  logic                  v2_q;
  side_t                 side2_q;
  logic signed [DXW-1:0] dx12_2q, dy12_2q, dx34_2q, dy34_2q;
  logic signed [DETW-1:0] det2_q;
  logic signed [AW-1:0]  a2_q, b2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side1_q;
      dx12_2q <= dx12_q;
      dy12_2q <= dy12_q;
      dx34_2q <= dx34_q;
      dy34_2q <= dy34_q;
      det2_q  <= DETW'(pd1_q) - DETW'(pd2_q);
      a2_q    <= AW'(pa1_q) - AW'(pa2_q);
      b2_q    <= AW'(pb1_q) - AW'(pb2_q);
    end
  end

  // stage 3: numerator products and parallel test
  logic [DETW-1:0] adet2;
  logic [LW-1:0]   lim;
  side_t           side3_d;
  assign adet2 = det2_q[DETW-1] ? DETW'(-det2_q) : DETW'(det2_q);
  assign lim   = {tol_q, {FRACTION_BITS{1'b0}}};
  always_comb begin
    side3_d      = side2_q;
    side3_d.coll = CW'(adet2) <= CW'(lim);
  end

  logic                  v3_q;
  side_t                 side3_q;
  logic signed [DETW-1:0] det3_q;
  logic signed [MW-1:0]  mx1_q, mx2_q, my1_q, my2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side3_d;
      det3_q  <= det2_q;
      mx1_q   <= MW'(dx34_2q) * MW'(a2_q);
      mx2_q   <= MW'(dx12_2q) * MW'(b2_q);
      my1_q   <= MW'(dy34_2q) * MW'(a2_q);
      my2_q   <= MW'(dy12_2q) * MW'(b2_q);
    end
  end

  // stage 4: numerators
  logic                  v4_q;
  side_t                 side4_q;
  logic signed [DETW-1:0] det4_q;
  logic signed [NW-1:0]  nx4_q, ny4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side3_q;
      det4_q  <= det3_q;
      nx4_q   <= NW'(mx1_q) - NW'(mx2_q);
      ny4_q   <= NW'(my1_q) - NW'(my2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= pair_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // divider entry
  logic [DETW-1:0] adet4;
  logic [NW-1:0]   anx4, any4;
  div_ctl_t        ctlx_d, ctly_d, ctlx_o, ctly_o;
  logic signed [W-1:0] qx, qy;

  assign adet4 = det4_q[DETW-1] ? DETW'(-det4_q) : DETW'(det4_q);
  assign anx4  = nx4_q[NW-1] ? NW'(-nx4_q) : NW'(nx4_q);
  assign any4  = ny4_q[NW-1] ? NW'(-ny4_q) : NW'(ny4_q);

  always_comb begin
    ctlx_d.valid = v4_q;
    ctlx_d.neg   = nx4_q[NW-1] ^ det4_q[DETW-1];
    ctly_d.valid = v4_q;
    ctly_d.neg   = ny4_q[NW-1] ^ det4_q[DETW-1];
  end

  segi_div #(.W(W), .NW(NW), .DW(DETW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctlx_d), .n_i(anx4), .d_i(adet4),
    .ctl_o(ctlx_o), .q_o(qx)
  );

  segi_div #(.W(W), .NW(NW), .DW(DETW)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(ctly_d), .n_i(any4), .d_i(adet4),
    .ctl_o(ctly_o), .q_o(qy)
  );

  // sideband alongside the divider
  side_t side_q [W+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side4_q;
      for (int s = 1; s <= W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // output stage
  side_t               st;
  logic                hit_d;
  logic signed [W-1:0] px_d, py_d;
  assign st = side_q[W];

  always_comb begin
    if (st.coll) begin
      hit_d = st.chit;
      px_d  = st.cx;
      py_d  = st.cy;
    end else begin
      px_d  = qx;
      py_d  = qy;
      hit_d = in_box(qx, st.b1xlo, st.b1xhi) && in_box(qx, st.b2xlo, st.b2xhi) &&
              in_box(qy, st.b1ylo, st.b1yhi) && in_box(qy, st.b2ylo, st.b2yhi);
    end
  end

  logic                hit_q, coll_q;
  logic signed [W-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctlx_o.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      coll_q <= st.coll;
      px_q   <= px_d;
      py_q   <= py_d;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.hit     = hit_q;
  assign result_o.point_x = px_q;
  assign result_o.point_y = py_q;

  a_coll_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && coll_q && !hit_q |-> px_q == '0 && py_q == '0)
    else $error("collinear miss with nonzero point");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pair_i.ready |-> out_valid_q && !result_o.ready)
    else $error("input stalled without a waiting result");

  a_div_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctlx_o.valid == ctly_o.valid)
    else $error("divider lanes out of step");

endmodule

// File: dv/tb_segment_intersection_core.sv
// testbench for segment_intersection_core: directed and random segment pairs with a local predictor
`timescale 1ns / 100ps

module tb_segment_intersection_core;
  import segi_pkg::*;

  localparam int unsigned CW       = 16;
  localparam int unsigned FB       = 12;
  localparam int unsigned LATENCY  = CW + 6;
  localparam int unsigned WD_LIMIT = 4000;
  localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x1, y1, x2, y2, x3, y3, x4, y4;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t px;
    coord_t py;
  } crossing_t;

  logic clk_i;
  logic rst_ni;
  logic tol_we_i;
  logic [TOL_W-1:0] tol_wdata_i;

  segi_pair_if   #(.W(CW)) pair_bus ();
  segi_result_if #(.W(CW)) result_bus ();

  segment_intersection_core #(
    .COORD_WIDTH  (CW),
    .FRACTION_BITS(FB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tol_we_i   (tol_we_i),
    .tol_wdata_i(tol_wdata_i),
    .pair_i     (pair_bus),
    .result_o   (result_bus)
  );

  crossing_t   pending_crossings[$];
  logic [TOL_W-1:0] tol_shadow;
  int unsigned error_cnt;
  int unsigned quiet_cycles;
  bit          idle_en;
  int unsigned stall_left;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint clamp_coord(longint v);
    if (v > longint'($signed(COORD_MAX))) return longint'($signed(COORD_MAX));
    if (v < longint'($signed(COORD_MIN))) return longint'($signed(COORD_MIN));
    return v;
  endfunction

  function automatic bit in_span(longint p, longint a, longint b, longint tol);
    longint lo, hi;
    lo = ((a < b) ? a : b) - tol;
    hi = ((a < b) ? b : a) + tol;
    return (p >= lo) && (p <= hi);
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s, logic [TOL_W-1:0] tol_reg);
    crossing_t r;
    longint x1, y1, x2, y2, x3, y3, x4, y4, tol;
    longint dx12, dy12, dx34, dy34, det, mag, a, b, nx, ny, px, py;
    x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
    x3 = s.x3; y3 = s.y3; x4 = s.x4; y4 = s.y4;
    tol = longint'(tol_reg);
    dx12 = x1 - x2; dy12 = y1 - y2;
    dx34 = x3 - x4; dy34 = y3 - y4;
    det = dx12 * dy34 - dy12 * dx34;
    mag = (det < 0) ? -det : det;
    if (mag <= (tol <<< FB)) begin
      if (in_span(x3, x1, x2, tol) && in_span(y3, y1, y2, tol)) begin
        r.hit = 1'b1; px = x3; py = y3;
      end else if (in_span(x4, x1, x2, tol) && in_span(y4, y1, y2, tol)) begin
        r.hit = 1'b1; px = x4; py = y4;
      end else begin
        r.hit = 1'b0; px = 0; py = 0;
      end
    end else begin
      a = x1 * y2 - y1 * x2;
      b = x3 * y4 - y3 * x4;
      nx = dx34 * a - dx12 * b;
      ny = dy34 * a - dy12 * b;
      px = clamp_coord(nx / det);
      py = clamp_coord(ny / det);
      r.hit = in_span(px, x1, x2, tol) && in_span(px, x3, x4, tol) &&
              in_span(py, y1, y2, tol) && in_span(py, y3, y4, tol);
    end
    r.px = coord_t'(px);
    r.py = coord_t'(py);
    return r;
  endfunction

  function automatic coord_t rand_coord(int unsigned span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic seg_pair_t make_pair(longint x1, longint y1, longint x2, longint y2,
                                          longint x3, longint y3, longint x4, longint y4);
    seg_pair_t s;
    s.x1 = coord_t'(clamp_coord(x1)); s.y1 = coord_t'(clamp_coord(y1));
    s.x2 = coord_t'(clamp_coord(x2)); s.y2 = coord_t'(clamp_coord(y2));
    s.x3 = coord_t'(clamp_coord(x3)); s.y3 = coord_t'(clamp_coord(y3));
    s.x4 = coord_t'(clamp_coord(x4)); s.y4 = coord_t'(clamp_coord(y4));
    return s;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    longint cx, cy, ax, ay, bx, by, k, ox, oy;
    int unsigned span;
    span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(16, 12000);
    cx = rand_coord(span); cy = rand_coord(span);
    ax = rand_coord(span); ay = rand_coord(span);
    bx = rand_coord(span); by = rand_coord(span);
    case ($urandom_range(0, 9))
      0, 1: begin
        s.x1 = coord_t'($urandom); s.y1 = coord_t'($urandom);
        s.x2 = coord_t'($urandom); s.y2 = coord_t'($urandom);
        s.x3 = coord_t'($urandom); s.y3 = coord_t'($urandom);
        s.x4 = coord_t'($urandom); s.y4 = coord_t'($urandom);
      end
      2: begin
        // parallel, offset sideways
        ox = rand_coord(span / 4 + 1); oy = rand_coord(span / 4 + 1);
        s = make_pair(cx - ax, cy - ay, cx + ax, cy + ay,
                      cx - ax + ox, cy - ay + oy, cx + bx / 2 + ox,
                      cy + bx / 2 * ay / (ax == 0 ? 1 : ax) + oy);
      end
      3, 4: begin
        // collinear pieces on one carrier line
        k = $urandom_range(0, 3);
        s = make_pair(cx, cy, cx + ax, cy + ax * k,
                      cx + bx, cy + bx * k, cx + by, cy + by * k);
      end
      default: begin
        // crossing around a common point
        s = make_pair(cx - ax, cy - ay, cx + ax, cy + ay, cx - bx, cy - by, cx + bx, cy + by);
      end
    endcase
    return s;
  endfunction

  task automatic send_pair(seg_pair_t s);
    pair_bus.first_start_x  = s.x1;
    pair_bus.first_start_y  = s.y1;
    pair_bus.first_end_x    = s.x2;
    pair_bus.first_end_y    = s.y2;
    pair_bus.second_start_x = s.x3;
    pair_bus.second_start_y = s.y3;
    pair_bus.second_end_x   = s.x4;
    pair_bus.second_end_y   = s.y4;
    pair_bus.valid          = 1'b1;
    do @(posedge clk_i); while (!pair_bus.ready);
    pending_crossings.push_back(predict_crossing(s, tol_shadow));
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      pair_bus.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    pair_bus.valid = 1'b0;
    while (pending_crossings.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] value);
    drain_and_settle();
    tol_we_i    = 1'b1;
    tol_wdata_i = value;
    @(negedge clk_i);
    tol_we_i    = 1'b0;
    tol_shadow  = value;
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  task automatic test_directed();
    // extremes and degenerate pairs
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
    // plain crossing, touching ends, near miss inside tolerance
    send_pair(make_pair(-4096, 0, 4096, 0, 0, -4096, 0, 4096));
    send_pair(make_pair(0, 0, 4096, 4096, 4096, 4096, 8192, 0));
    send_pair(make_pair(-4096, 0, 4096, 0, 0, 3, 0, 4096));
    // crossing outside boxes, and far crossing that saturates
    send_pair(make_pair(0, 0, 100, 100, 300, 0, 400, -100));
    send_pair(make_pair(-32768, 0, -32000, 1, -32768, 2, -32000, 4));
    send_pair(make_pair(32000, 0, 32767, 3, 32000, 2, 32767, 3));
    send_pair(make_pair(0, 0, 1, 32767, 3, 0, 2, 32767));
    // parallel, collinear hit at second start, at second end, collinear miss
    send_pair(make_pair(0, 0, 8192, 0, 0, 4096, 8192, 4096));
    send_pair(make_pair(0, 0, 8192, 8192, 4096, 4096, 12000, 12000));
    send_pair(make_pair(0, 0, 8192, 8192, -8192, -8192, 4096, 4096));
    send_pair(make_pair(0, 0, 8192, 0, 9000, 0, 12000, 0));
    send_pair(make_pair(0, 0, 8192, 0, 8196, 0, 12000, 0));
    send_pair(make_pair(-32768, 5, 32767, 5, 32767, 5, -32768, 5));
    send_pair(make_pair(100, 100, 100, 100, 100, 100, 200, 300));
    send_pair(make_pair(0, 0, 3, 1, 0, 0, 6, 2));
  endtask

  task automatic test_tolerance_extremes();
    set_tolerance('0);
    test_directed();
    run_random(120);
    set_tolerance({TOL_W{1'b1}});
    test_directed();
    run_random(120);
  endtask

  task automatic test_random_tolerance();
    repeat (4) begin
      set_tolerance(($urandom_range(0, 1) == 0) ? TOL_W'($urandom_range(0, 64))
                                                 : TOL_W'($urandom));
      run_random(110);
    end
  endtask

  task automatic test_back_to_back();
    set_tolerance(TOL_RESET);
    idle_en = 1'b0;
    run_random(120);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left       <= stall_left - 1;
      result_bus.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left       <= $urandom_range(0, 12);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    crossing_t exp_c;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_crossings.size() == 0) begin
        $error("unexpected transfer: hit %0b x %0d y %0d",
               result_bus.hit, result_bus.point_x, result_bus.point_y);
        error_cnt++;
      end else begin
        exp_c = pending_crossings.pop_front();
        if (result_bus.hit !== exp_c.hit) begin
          $error("hit: expected %0b actual %0b", exp_c.hit, result_bus.hit);
          error_cnt++;
        end
        if (result_bus.point_x !== exp_c.px) begin
          $error("point_x: expected %0d actual %0d", exp_c.px, result_bus.point_x);
          error_cnt++;
        end
        if (result_bus.point_y !== exp_c.py) begin
          $error("point_y: expected %0d actual %0d", exp_c.py, result_bus.point_y);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pair_bus.valid && pair_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    error_cnt        = 0;
    quiet_cycles     = 0;
    stall_left       = 0;
    idle_en          = 1'b1;
    tol_shadow       = TOL_RESET;
    tol_we_i         = 1'b0;
    tol_wdata_i      = '0;
    pair_bus.valid   = 1'b0;
    pair_bus.first_start_x  = '0;
    pair_bus.first_start_y  = '0;
    pair_bus.first_end_x    = '0;
    pair_bus.first_end_y    = '0;
    pair_bus.second_start_x = '0;
    pair_bus.second_start_y = '0;
    pair_bus.second_end_x   = '0;
    pair_bus.second_end_y   = '0;
    result_bus.ready = 1'b0;
    rst_ni           = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_tolerance_extremes();
    test_random_tolerance();
    test_back_to_back();

    drain_and_settle();
    if (error_cnt == 0 && pending_crossings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
